// ----- rtl/stp_pkg.sv -----
// Shared types and constants for the square tone pattern player.
package stp_pkg;

  localparam int WORD_W   = 16;
  localparam int ADDR_W   = 8;
  localparam int NOTE_W   = 22;
  localparam int SAMPLE_W = 8;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int SAMPLE_RATE_DEF   = 48000;
  localparam int PATTERN_WORDS_DEF = 256;

  // milliseconds to seconds
  localparam int LEN_DIVISOR = 1000;

  localparam logic [WORD_W-1:0]   END_MARK = 16'h8000;
  localparam logic [SAMPLE_W-1:0] LEVEL_HI = 8'd160;
  localparam logic [SAMPLE_W-1:0] LEVEL_LO = 8'd96;
  localparam logic [SAMPLE_W-1:0] SILENCE  = 8'd0;
  localparam logic [NOTE_W-1:0]   NOTE_MAX = {NOTE_W{1'b1}};

  // register word index on the configuration port
  localparam logic CFG_AUDIO_EN = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PLAY  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_RDF   = 9'b000000100,
    S_RDD   = 9'b000001000,
    S_RDE   = 9'b000010000,
    S_ENDC  = 9'b000100000,
    S_DIVL  = 9'b001000000,
    S_DIVH  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

endpackage

// ----- rtl/square_tone_pattern_player.sv -----
// Square tone pattern player: pattern memory, note fetch, serial divider, tone generator.
//
// Plays a pattern of (frequency Hz, duration ms) word pairs, closed by the
// end word 0x8000, as an unsigned 8-bit square wave of 160/96, with 0 for
// rests and silence. A write transfer (operation 0) stores one word and a
// play transfer (operation 1) points the player at a start address; both
// give no result and leave the block ready for the next transfer. A tick
// transfer (operation 2) gives one sample. A tick that needs no new note
// passes through accept, update and load of the output register, the load
// waiting while an earlier result is still untaken. Each note fetched during
// a tick adds a check state and the read states RDF, RDD, RDE and ENDC of
// pattern memory on its single read port, then a restoring divider that
// settles one quotient bit per cycle, once for the note length
// (rate*ms/1000) and, for a tone only, once for the half period (rate/freq).
// Zero-length notes chain further fetches within the same tick, at most
// PATTERN_WORDS of them. The result sits in an output register, so the next
// transfer is taken while it waits. Clearing audio_enabled gives 0 samples
// and freezes playback.
module square_tone_pattern_player #(
  parameter int SAMPLE_RATE   = stp_pkg::SAMPLE_RATE_DEF,
  parameter int PATTERN_WORDS = stp_pkg::PATTERN_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [stp_pkg::ADDR_W-1:0]    address,
  input  logic [stp_pkg::WORD_W-1:0]    word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stp_pkg::SAMPLE_W-1:0]  sample,
  output logic                          playing,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stp_pkg::PADDR_W-1:0]   paddr,
  input  logic [stp_pkg::PDATA_W-1:0]   pwdata,
  output logic [stp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW  = $clog2(PATTERN_WORDS);
  localparam int MW  = AW + 5;                      // holds PATTERN_WORDS << 4
  localparam int CW  = $clog2(PATTERN_WORDS + 1);
  localparam int RW  = $clog2(SAMPLE_RATE + 1);
  localparam int WW  = stp_pkg::WORD_W;
  localparam int NW  = stp_pkg::NOTE_W;
  localparam int DVW = RW + WW;                     // rate * duration
  localparam int DCW = $clog2(DVW);
  localparam logic [DVW-1:0] RATE_W = DVW'(SAMPLE_RATE);

  // Reduce a position (at most 256) modulo the pattern size by binary
  // compare and subtract; positions stay below 32 times the size.
  function automatic logic [AW-1:0] wrap_index(input logic [8:0] v);
    logic [MW-1:0] r;
    r = MW'(v);
    for (int k = 4; k >= 0; k--) begin
      if (r >= (MW'(PATTERN_WORDS) << k)) begin
        r = r - (MW'(PATTERN_WORDS) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [NW-1:0] sat_note(input logic [DVW-1:0] q);
    if (|q[DVW-1:NW]) begin
      return stp_pkg::NOTE_MAX;
    end
    return q[NW-1:0];
  endfunction

  stp_pkg::state_t state;

  logic                         audio_enabled;
  logic [stp_pkg::ADDR_W-1:0]   play_pos;
  logic                         pattern_active;
  logic [NW-1:0]                note_left;
  logic [NW-1:0]                half_left;
  logic [WW-1:0]                tone_freq;
  logic [NW-1:0]                tone_half;
  logic                         level_high;
  logic [CW-1:0]                fetch_count;
  logic [stp_pkg::SAMPLE_W-1:0] res_sample;

  // serial divider
  logic [DVW-1:0] dividend;
  logic [WW-1:0]  rem;
  logic [DCW-1:0] dcnt;
  logic [WW-1:0]  div_divisor;
  logic [WW:0]    rem_sh;
  logic           div_fit;
  logic [WW-1:0]  rem_next;
  logic [DVW-1:0] quo_next;
  logic           div_last;
  logic [NW-1:0]  quo_sat;
  logic [NW-1:0]  half_min;

  // pattern memory
  logic [WW-1:0] store [PATTERN_WORDS];
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;
  logic          mem_we;
  logic          in_xfer;
  logic          cfg_we;
  logic [NW-1:0] hp_dec;

  assign in_ready = (state == stp_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign mem_we   = in_xfer && (operation == stp_pkg::OP_WRITE);
  assign wr_idx   = wrap_index({1'b0, address});
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == stp_pkg::CFG_AUDIO_EN) ?
                    {{(stp_pkg::PDATA_W-1){1'b0}}, audio_enabled} : '0;

  // Read port address: frequency, duration, then the word after the note
  // (play_pos has already moved on by the end-word read).
  always_comb begin
    case (state)
      stp_pkg::S_RDD: rd_idx = wrap_index({1'b0, play_pos} + 9'd1);
      default:        rd_idx = wrap_index({1'b0, play_pos});
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_idx] <= word;
    end
    rd_data <= store[rd_idx];
  end

  // One quotient bit per cycle.
  assign div_divisor = (state == stp_pkg::S_DIVH) ? tone_freq : WW'(stp_pkg::LEN_DIVISOR);
  assign rem_sh      = {rem, dividend[DVW-1]};
  assign div_fit     = (rem_sh >= {1'b0, div_divisor});
  assign rem_next    = div_fit ? WW'(rem_sh - {1'b0, div_divisor}) : rem_sh[WW-1:0];
  assign quo_next    = {dividend[DVW-2:0], div_fit};
  assign div_last    = (dcnt == DCW'(DVW - 1));
  assign quo_sat     = sat_note(quo_next);
  assign half_min    = (quo_sat == '0) ? NW'(1) : quo_sat;

  assign hp_dec = (half_left != '0) ? half_left - NW'(1) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= stp_pkg::S_IDLE;
      audio_enabled  <= 1'b1;
      play_pos       <= '0;
      pattern_active <= 1'b0;
      note_left      <= '0;
      half_left      <= '0;
      tone_freq      <= '0;
      level_high     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we && paddr[2] == stp_pkg::CFG_AUDIO_EN) begin
        audio_enabled <= pwdata[0];
      end
      // drop the result once taken; EMIT reloads it in the same cycle
      if (out_valid && out_ready && state != stp_pkg::S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        stp_pkg::S_IDLE: begin
          if (in_xfer) begin
            case (operation)
              stp_pkg::OP_PLAY: begin
                play_pos       <= address;
                pattern_active <= 1'b1;
              end
              stp_pkg::OP_TICK: begin
                fetch_count <= '0;
                state       <= stp_pkg::S_CHECK;
              end
              default: begin
              end
            endcase
          end
        end

        stp_pkg::S_CHECK: begin
          if (!audio_enabled) begin
            // hold all playback state
            res_sample <= stp_pkg::SILENCE;
            state      <= stp_pkg::S_EMIT;
          end else if (note_left != '0) begin
            note_left <= note_left - NW'(1);
            if (tone_freq == '0) begin
              res_sample <= stp_pkg::SILENCE;
            end else begin
              res_sample <= level_high ? stp_pkg::LEVEL_HI : stp_pkg::LEVEL_LO;
              if (hp_dec == '0) begin
                level_high <= ~level_high;
                half_left  <= tone_half;
              end else begin
                half_left <= hp_dec;
              end
            end
            state <= stp_pkg::S_EMIT;
          end else if (pattern_active && fetch_count != CW'(PATTERN_WORDS)) begin
            state <= stp_pkg::S_RDF;
          end else begin
            res_sample <= stp_pkg::SILENCE;
            state      <= stp_pkg::S_EMIT;
          end
        end

        stp_pkg::S_RDF: begin
          state <= stp_pkg::S_RDD;
        end

        stp_pkg::S_RDD: begin
          tone_freq <= rd_data;
          play_pos  <= play_pos + stp_pkg::ADDR_W'(2);
          state     <= stp_pkg::S_RDE;
        end

        stp_pkg::S_RDE: begin
          dividend <= RATE_W * DVW'(rd_data);
          rem      <= '0;
          state    <= stp_pkg::S_ENDC;
        end

        stp_pkg::S_ENDC: begin
          if (rd_data == stp_pkg::END_MARK) begin
            pattern_active <= 1'b0;
          end
          fetch_count <= fetch_count + CW'(1);
          dcnt        <= '0;
          state       <= stp_pkg::S_DIVL;
        end

        stp_pkg::S_DIVL: begin
          if (div_last) begin
            note_left <= quo_sat;
            if (tone_freq != '0) begin
              dividend <= RATE_W;
              rem      <= '0;
              dcnt     <= '0;
              state    <= stp_pkg::S_DIVH;
            end else begin
              // a rest counts its half period along with its length
              half_left <= quo_sat;
              state     <= stp_pkg::S_CHECK;
            end
          end else begin
            rem      <= rem_next;
            dividend <= quo_next;
            dcnt     <= dcnt + DCW'(1);
          end
        end

        stp_pkg::S_DIVH: begin
          rem      <= rem_next;
          dividend <= quo_next;
          dcnt     <= dcnt + DCW'(1);
          if (div_last) begin
            tone_half <= half_min;
            half_left <= half_min;
            state     <= stp_pkg::S_CHECK;
          end
        end

        stp_pkg::S_EMIT: begin
          if (!out_valid || out_ready) begin
            sample    <= res_sample;
            playing   <= pattern_active || (note_left != '0);
            out_valid <= 1'b1;
            state     <= stp_pkg::S_IDLE;
          end
        end

        default: begin
          state <= stp_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Muted tick leaves playback untouched.
  a_muted_frozen: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && operation == stp_pkg::OP_TICK && !audio_enabled) |=>
      ($stable(note_left) && $stable(play_pos) && $stable(pattern_active)))
    else $error("muted tick changed playback state");

  // A sounding tone always has a nonzero half period reload.
  a_half_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == stp_pkg::S_CHECK && tone_freq != '0) |-> (tone_half != '0))
    else $error("zero half period on a tone");

  // Fetch chain bounded by the pattern size.
  a_fetch_bound: assert property (@(posedge clk) disable iff (rst)
    (state == stp_pkg::S_CHECK) |-> (fetch_count <= CW'(PATTERN_WORDS)))
    else $error("fetch chain ran past the pattern size");

  // Partial remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == stp_pkg::S_DIVL || state == stp_pkg::S_DIVH) |-> (rem < div_divisor))
    else $error("divider remainder out of range");

endmodule

// ----- verif/square_tone_pattern_player_checker.sv -----
// Checker for the square tone pattern player: watches transfers, predicts samples, compares.
module square_tone_pattern_player_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [stp_pkg::ADDR_W-1:0]    address,
  input  logic [stp_pkg::WORD_W-1:0]    word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [stp_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          playing,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [stp_pkg::PADDR_W-1:0]   paddr,
  input  logic [stp_pkg::PDATA_W-1:0]   pwdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RATE  = stp_pkg::SAMPLE_RATE_DEF;
  localparam int          DEPTH = stp_pkg::PATTERN_WORDS_DEF;
  localparam int          REPORT_LIMIT = 10;
  localparam logic [stp_pkg::PADDR_W-1:0] AUDIO_EN_ADDR = {stp_pkg::CFG_AUDIO_EN, 2'b00};

  typedef struct packed {
    logic [stp_pkg::SAMPLE_W-1:0] sample;
    logic                         playing;
  } tone_result_t;

  // predicted player state
  logic [stp_pkg::WORD_W-1:0] pattern_mem [DEPTH];
  logic [stp_pkg::ADDR_W-1:0] cursor;
  logic                       sequence_on;
  logic [stp_pkg::NOTE_W-1:0] note_left;
  logic [stp_pkg::NOTE_W-1:0] half_left;
  logic [stp_pkg::WORD_W-1:0] cur_freq;
  logic                       level_up;
  logic                       audio_on;

  tone_result_t expected_samples [$];
  int           errors;

  function automatic logic [stp_pkg::NOTE_W-1:0] half_period(
      input logic [stp_pkg::WORD_W-1:0] freq);
    int unsigned h;
    h = RATE / freq;
    if (h < 1) h = 1;
    if (h > stp_pkg::NOTE_MAX) h = stp_pkg::NOTE_MAX;
    return h[stp_pkg::NOTE_W-1:0];
  endfunction

  // Read the pair at the cursor, size the note, advance past it.
  function automatic void load_note();
    logic [stp_pkg::WORD_W-1:0] freq;
    logic [stp_pkg::WORD_W-1:0] dur;
    logic [stp_pkg::ADDR_W-1:0] dur_at;
    longint unsigned            len;
    dur_at = cursor + 1'b1;
    freq   = pattern_mem[cursor];
    dur    = pattern_mem[dur_at];
    len    = (longint'(RATE) * dur) / stp_pkg::LEN_DIVISOR;
    if (len > stp_pkg::NOTE_MAX) len = stp_pkg::NOTE_MAX;
    cur_freq  = freq;
    note_left = len[stp_pkg::NOTE_W-1:0];
    half_left = (freq != 0) ? half_period(freq) : len[stp_pkg::NOTE_W-1:0];
    cursor    = cursor + 2'd2;
    if (pattern_mem[cursor] == stp_pkg::END_MARK) sequence_on = 1'b0;
  endfunction

  function automatic logic [stp_pkg::SAMPLE_W-1:0] next_tone_sample();
    logic [stp_pkg::SAMPLE_W-1:0] level;
    for (int n = 0; n < DEPTH; n++) begin
      if (sequence_on && note_left == 0) load_note();
      if (note_left == 0) begin
        if (!sequence_on) return stp_pkg::SILENCE;
        continue;
      end
      if (cur_freq == 0) begin
        note_left--;
        return stp_pkg::SILENCE;
      end
      level = level_up ? stp_pkg::LEVEL_HI : stp_pkg::LEVEL_LO;
      if (half_left > 0) half_left--;
      note_left--;
      if (half_left == 0) begin
        level_up  = !level_up;
        half_left = half_period(cur_freq);
      end
      return level;
    end
    // runaway chain of empty notes: silence now, resume fetching on the next tick
    return stp_pkg::SILENCE;
  endfunction

  always @(posedge clk) begin
    tone_result_t got;
    tone_result_t want;
    if (rst) begin
      cursor      = '0;
      sequence_on = 1'b0;
      note_left   = '0;
      half_left   = '0;
      cur_freq    = '0;
      level_up    = 1'b0;
      audio_on    = 1'b1;
      errors      = 0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == AUDIO_EN_ADDR)
        audio_on = pwdata[0];

      if (in_valid && in_ready) begin
        case (operation)
          stp_pkg::OP_WRITE: pattern_mem[address] = word;
          stp_pkg::OP_PLAY: begin
            cursor      = address;
            sequence_on = 1'b1;
          end
          stp_pkg::OP_TICK: begin
            want.sample = stp_pkg::SILENCE;
            if (audio_on) want.sample = next_tone_sample();
            want.playing = sequence_on || note_left != 0;
            expected_samples.push_back(want);
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got.sample  = sample;
        got.playing = playing;
        if (expected_samples.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: unexpected result sample=%0d playing=%0d", $realtime,
                     got.sample, got.playing);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (got != want) begin
            if (errors < REPORT_LIMIT)
              $display("%0t: mismatch sample exp=%0d got=%0d, playing exp=%0d got=%0d",
                       $realtime, want.sample, got.sample, want.playing, got.playing);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_samples.size();
  end

endmodule

// ----- verif/tb_square_tone_pattern_player.sv -----
// Testbench top for the square tone pattern player: clock, reset, stimulus and verdict.
module tb_square_tone_pattern_player;
  timeunit 1ns;
  timeprecision 1ps;

  // operation code the block must ignore
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int CYCLE_LIMIT  = 1_500_000;
  // settling time after the last predicted sample; leave ample slack
  localparam int DRAIN_CYCLES = 150;
  localparam int MS_SAMPLES   = stp_pkg::SAMPLE_RATE_DEF / stp_pkg::LEN_DIVISOR;
  localparam logic [stp_pkg::PADDR_W-1:0] AUDIO_EN_ADDR = {stp_pkg::CFG_AUDIO_EN, 2'b00};

  // audio setting per phase, and the least number of transfers each phase carries
  localparam int         PHASES      = 5;
  localparam logic [4:0] PHASE_AUDIO = 5'b10101;
  localparam int         ITEMS_ON    = 230;
  localparam int         ITEMS_OFF   = 90;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    operation;
  logic [stp_pkg::ADDR_W-1:0]    address;
  logic [stp_pkg::WORD_W-1:0]    word;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [stp_pkg::SAMPLE_W-1:0]  sample;
  logic                          playing;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [stp_pkg::PADDR_W-1:0]   paddr;
  logic [stp_pkg::PDATA_W-1:0]   pwdata;
  logic [stp_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       burst_left;
  int       items_sent;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_hold = 0;

  square_tone_pattern_player i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .address   (address),
    .word      (word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .playing   (playing),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  square_tone_pattern_player_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .address    (address),
    .word       (word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample),
    .playing    (playing),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost sample ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: hold one stall mode for a random stretch, then draw the mode again at random.
  // Open stretches give runs with no back-pressure at all.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_hold = $urandom_range(20, 200);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Offer one transfer, held until in_ready reads high after an edge. The sender
  // works in bursts; between bursts drop valid for a random gap (sometimes none).
  task automatic send(input logic [1:0] op, input logic [stp_pkg::ADDR_W-1:0] addr,
                      input logic [stp_pkg::WORD_W-1:0] data);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    operation <= op;
    address   <= addr;
    word      <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (op != OP_RESERVED) items_sent++;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send(stp_pkg::OP_TICK, stp_pkg::ADDR_W'($urandom()),
                        stp_pkg::WORD_W'($urandom()));
  endtask

  // Drop valid, wait for every predicted sample to arrive, then let the
  // block settle so a trailing write or play is surely done.
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; upper data bits are don't-care.
  task automatic set_audio(input logic enable);
    logic [stp_pkg::PDATA_W-1:0] value;
    value    = $urandom();
    value[0] = enable;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AUDIO_EN_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Well-formed pattern: a few notes at an even base, closed by the end
  // word, then play it. Durations live at odd addresses and stay at a few
  // milliseconds so that no note runs for minutes; any word goes at even
  // addresses. Mostly tick the pattern out, otherwise cut it short so the
  // next play lands in the middle of a note.
  task automatic play_pattern();
    logic [stp_pkg::ADDR_W-1:0] base;
    logic [stp_pkg::ADDR_W-1:0] at;
    logic [stp_pkg::WORD_W-1:0] freq;
    logic [stp_pkg::WORD_W-1:0] dur;
    int                         notes;
    int                         samples;
    int                         pick;
    base    = stp_pkg::ADDR_W'($urandom_range(0, 127) * 2);
    at      = base;
    notes   = $urandom_range(1, 3);
    samples = 0;
    for (int k = 0; k < notes; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    freq = '0;
        2:       freq = stp_pkg::WORD_W'($urandom_range(24000, 65535));
        3:       freq = stp_pkg::WORD_W'($urandom_range(1, 40));
        default: freq = stp_pkg::WORD_W'($urandom_range(100, 8000));
      endcase
      pick = $urandom_range(0, 19);
      dur  = (pick < 4) ? 16'd0 : (pick < 17) ? 16'd1 : 16'd2;
      send(stp_pkg::OP_WRITE, at, freq);
      at = at + 1'b1;
      send(stp_pkg::OP_WRITE, at, dur);
      at = at + 1'b1;
      samples += dur * MS_SAMPLES;
    end
    send(stp_pkg::OP_WRITE, at, stp_pkg::END_MARK);
    send(stp_pkg::OP_PLAY, base, stp_pkg::WORD_W'($urandom()));
    if ($urandom_range(0, 9) < 7) send_ticks(samples + $urandom_range(1, 4));
    else send_ticks($urandom_range(1, 40));
  endtask

  // Noise between patterns: stray writes, plays from anywhere even,
  // reserved codes and loose ticks. Keep odd words short as above.
  task automatic stray_items();
    logic [stp_pkg::ADDR_W-1:0] addr;
    logic [stp_pkg::WORD_W-1:0] data;
    repeat ($urandom_range(1, 4)) begin
      addr = stp_pkg::ADDR_W'($urandom());
      data = stp_pkg::WORD_W'($urandom());
      case ($urandom_range(0, 3))
        0: begin
          if (addr[0]) data = stp_pkg::WORD_W'($urandom_range(0, 2));
          send(stp_pkg::OP_WRITE, addr, data);
        end
        1: begin
          addr[0] = 1'b0;
          send(stp_pkg::OP_PLAY, addr, data);
        end
        2:       send(OP_RESERVED, addr, data);
        default: send_ticks(1);
      endcase
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    operation  = stp_pkg::OP_WRITE;
    address    = '0;
    word       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    burst_left = 0;
    items_sent = 0;
    rst        = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_audio(1'b1);

    // Clear the whole store first so that no fetch ever reads an unwritten word.
    for (int a = 0; a < stp_pkg::PATTERN_WORDS_DEF; a++)
      send(stp_pkg::OP_WRITE, stp_pkg::ADDR_W'(a), '0);

    // Play an all-empty store: each tick gives up after a full round of
    // zero-length fetches and reports silence while still playing.
    send(stp_pkg::OP_PLAY, 8'h00, 16'hFFFF);
    send_ticks(2);
    send(OP_RESERVED, 8'hFF, 16'hFFFF);

    // Highest frequency (half period clamps to one), a rest, a zero-length
    // note that is skipped, the lowest frequency, then the end word.
    send(stp_pkg::OP_WRITE, 8'h10, 16'hFFFF);
    send(stp_pkg::OP_WRITE, 8'h11, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h12, 16'd0);
    send(stp_pkg::OP_WRITE, 8'h13, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h14, 16'd440);
    send(stp_pkg::OP_WRITE, 8'h15, 16'd0);
    send(stp_pkg::OP_WRITE, 8'h16, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h17, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h18, stp_pkg::END_MARK);
    send(stp_pkg::OP_PLAY, 8'h10, 16'h0000);
    send_ticks(3 * MS_SAMPLES + 3);

    // Odd start address; afterwards restore a short word at the odd slot.
    send(stp_pkg::OP_WRITE, 8'h21, 16'd2);
    send(stp_pkg::OP_WRITE, 8'h22, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h23, stp_pkg::END_MARK);
    send(stp_pkg::OP_PLAY, 8'h21, 16'h5555);
    send_ticks(MS_SAMPLES + 2);
    send(stp_pkg::OP_WRITE, 8'h23, 16'd1);

    // Note pair at the top of the store, end word wrapped to address zero;
    // replay mid-note so the current note has to finish first.
    send(stp_pkg::OP_WRITE, 8'hFE, 16'd2000);
    send(stp_pkg::OP_WRITE, 8'hFF, 16'd1);
    send(stp_pkg::OP_WRITE, 8'h00, stp_pkg::END_MARK);
    send(stp_pkg::OP_PLAY, 8'hFE, 16'hAAAA);
    send_ticks(10);
    send(stp_pkg::OP_PLAY, 8'h10, 16'h0000);
    send_ticks(3 * MS_SAMPLES + 45);
    drain();

    // Random phases, alternating audio on and off; reprogram only when idle.
    for (int p = 0; p < PHASES; p++) begin
      set_audio(PHASE_AUDIO[p]);
      items_sent = 0;
      while (items_sent < (PHASE_AUDIO[p] ? ITEMS_ON : ITEMS_OFF)) begin
        play_pattern();
        if ($urandom_range(0, 5) == 0) stray_items();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/stp_pkg.sv
rtl/square_tone_pattern_player.sv
verif/square_tone_pattern_player_checker.sv
verif/tb_square_tone_pattern_player.sv
